@@ sv/dtp_pkg.sv @@
package dtp_pkg;

    localparam int PHASE_W = 5;

    localparam logic [PHASE_W-1:0] PH_YEAR0  = 5'd0;
    localparam logic [PHASE_W-1:0] PH_YEAR1  = 5'd1;
    localparam logic [PHASE_W-1:0] PH_YEAR2  = 5'd2;
    localparam logic [PHASE_W-1:0] PH_YEAR3  = 5'd3;
    localparam logic [PHASE_W-1:0] PH_DASH1  = 5'd4;
    localparam logic [PHASE_W-1:0] PH_MONTH0 = 5'd5;
    localparam logic [PHASE_W-1:0] PH_MONTH1 = 5'd6;
    localparam logic [PHASE_W-1:0] PH_DASH2  = 5'd7;
    localparam logic [PHASE_W-1:0] PH_DAY0   = 5'd8;
    localparam logic [PHASE_W-1:0] PH_DAY1   = 5'd9;
    localparam logic [PHASE_W-1:0] PH_SPACE  = 5'd10;
    localparam logic [PHASE_W-1:0] PH_HOUR0  = 5'd11;
    localparam logic [PHASE_W-1:0] PH_HOUR1  = 5'd12;
    localparam logic [PHASE_W-1:0] PH_COLON1 = 5'd13;
    localparam logic [PHASE_W-1:0] PH_MIN0   = 5'd14;
    localparam logic [PHASE_W-1:0] PH_MIN1   = 5'd15;
    localparam logic [PHASE_W-1:0] PH_OPTCOL = 5'd16;
    localparam logic [PHASE_W-1:0] PH_SEC0   = 5'd17;
    localparam logic [PHASE_W-1:0] PH_SEC1   = 5'd18;
    localparam logic [PHASE_W-1:0] PH_DONE   = 5'd19;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [13:0] YEAR_MIN  = 14'd2000;
    localparam logic [13:0] YEAR_MAX  = 14'd2099;
    localparam logic [6:0]  MONTH_MAX = 7'd12;
    localparam logic [6:0]  DAY_MAX   = 7'd31;
    localparam logic [6:0]  HOUR_MAX  = 7'd23;
    localparam logic [6:0]  MINSEC_MAX = 7'd59;

    localparam int TDATA_W = 40;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } in_item_t;

    typedef struct packed {
        logic        ok;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } result_t;

endpackage

@@ sv/dtp_in_stage.sv @@
module dtp_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // ch
    input  logic              s_tlast,
    input  logic              take,
    output logic              item_valid,
    output dtp_pkg::in_item_t item
);

    logic              valid_reg;
    logic              valid_next;
    dtp_pkg::in_item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.ch  <= s_tdata;
            item_reg.eot <= s_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ sv/dtp_core.sv @@
module dtp_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    input  dtp_pkg::in_item_t item,
    output logic              take,
    input  logic              res_ready,
    output logic              res_valid,
    output dtp_pkg::result_t  res
);

    logic [dtp_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic                        failed_reg, failed_next;
    logic [13:0]                 year_reg, year_next;
    logic [6:0]                  month_reg, month_next;
    logic [6:0]                  day_reg, day_next;
    logic [6:0]                  hour_reg, hour_next;
    logic [6:0]                  minute_reg, minute_next;
    logic [6:0]                  second_reg, second_next;
    logic                        res_valid_reg, res_valid_next;
    dtp_pkg::result_t            res_reg, res_next;

    logic       is_digit;
    logic [3:0] digit;
    logic       good;

    function automatic logic [6:0] acc10_7(input logic [6:0] acc, input logic [3:0] d);
        logic [9:0] t;
        t = {acc, 3'b000} + {2'b00, acc, 1'b0} + {6'b000000, d};
        return t[6:0];
    endfunction

    function automatic logic [13:0] acc10_14(input logic [13:0] acc, input logic [3:0] d);
        logic [16:0] t;
        t = {acc, 3'b000} + {2'b00, acc, 1'b0} + {13'd0, d};
        return t[13:0];
    endfunction

    assign is_digit = (item.ch >= dtp_pkg::CH_ZERO) && (item.ch <= dtp_pkg::CH_NINE);
    assign digit    = item.ch[3:0];
    assign take     = item_valid && (!item.eot || !res_valid_reg || res_ready);

    assign good = !failed_reg
        && (phase_reg == dtp_pkg::PH_OPTCOL || phase_reg == dtp_pkg::PH_DONE)
        && year_reg >= dtp_pkg::YEAR_MIN && year_reg <= dtp_pkg::YEAR_MAX
        && month_reg != 7'd0 && month_reg <= dtp_pkg::MONTH_MAX
        && day_reg != 7'd0 && day_reg <= dtp_pkg::DAY_MAX
        && hour_reg <= dtp_pkg::HOUR_MAX
        && minute_reg <= dtp_pkg::MINSEC_MAX
        && second_reg <= dtp_pkg::MINSEC_MAX;

    always_comb begin
        phase_next  = phase_reg;
        failed_next = failed_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        res_next    = res_reg;
        res_valid_next = res_valid_reg && !res_ready;

        if (take && item.eot) begin
            res_valid_next = 1'b1;
            res_next = '0;
            if (good) begin
                res_next.ok     = 1'b1;
                res_next.year   = year_reg[11:0];
                res_next.month  = month_reg[3:0];
                res_next.day    = day_reg[4:0];
                res_next.hour   = hour_reg[4:0];
                res_next.minute = minute_reg[5:0];
                res_next.second = second_reg[5:0];
            end
            phase_next  = dtp_pkg::PH_YEAR0;
            failed_next = 1'b0;
            year_next   = '0;
            month_next  = '0;
            day_next    = '0;
            hour_next   = '0;
            minute_next = '0;
            second_next = '0;
        end else if (take && !failed_reg && phase_reg != dtp_pkg::PH_DONE
                     && !(phase_reg == dtp_pkg::PH_YEAR0
                          && (item.ch == dtp_pkg::CH_SPACE || item.ch == dtp_pkg::CH_TAB))) begin
            phase_next = phase_reg + 5'd1;
            unique case (phase_reg)
                dtp_pkg::PH_YEAR0, dtp_pkg::PH_YEAR1,
                dtp_pkg::PH_YEAR2, dtp_pkg::PH_YEAR3: begin
                    if (!is_digit) failed_next = 1'b1;
                    else year_next = acc10_14(year_reg, digit);
                end
                dtp_pkg::PH_MONTH0, dtp_pkg::PH_MONTH1: begin
                    if (!is_digit) failed_next = 1'b1;
                    else month_next = acc10_7(month_reg, digit);
                end
                dtp_pkg::PH_DAY0, dtp_pkg::PH_DAY1: begin
                    if (!is_digit) failed_next = 1'b1;
                    else day_next = acc10_7(day_reg, digit);
                end
                dtp_pkg::PH_HOUR0, dtp_pkg::PH_HOUR1: begin
                    if (!is_digit) failed_next = 1'b1;
                    else hour_next = acc10_7(hour_reg, digit);
                end
                dtp_pkg::PH_MIN0, dtp_pkg::PH_MIN1: begin
                    if (!is_digit) failed_next = 1'b1;
                    else minute_next = acc10_7(minute_reg, digit);
                end
                dtp_pkg::PH_SEC0, dtp_pkg::PH_SEC1: begin
                    if (!is_digit) failed_next = 1'b1;
                    else second_next = acc10_7(second_reg, digit);
                end
                dtp_pkg::PH_DASH1, dtp_pkg::PH_DASH2: begin
                    if (item.ch != dtp_pkg::CH_DASH) failed_next = 1'b1;
                end
                dtp_pkg::PH_SPACE: begin
                    if (item.ch != dtp_pkg::CH_SPACE) failed_next = 1'b1;
                end
                dtp_pkg::PH_COLON1: begin
                    if (item.ch != dtp_pkg::CH_COLON) failed_next = 1'b1;
                end
                dtp_pkg::PH_OPTCOL: begin
                    phase_next = (item.ch == dtp_pkg::CH_COLON) ? dtp_pkg::PH_SEC0
                                                                : dtp_pkg::PH_DONE;
                end
                default: begin
                    failed_next = 1'b1;
                end
            endcase
            if (failed_next) phase_next = phase_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= dtp_pkg::PH_YEAR0;
            failed_reg    <= 1'b0;
            year_reg      <= '0;
            month_reg     <= '0;
            day_reg       <= '0;
            hour_reg      <= '0;
            minute_reg    <= '0;
            second_reg    <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            failed_reg    <= failed_next;
            year_reg      <= year_next;
            month_reg     <= month_next;
            day_reg       <= day_next;
            hour_reg      <= hour_next;
            minute_reg    <= minute_next;
            second_reg    <= second_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

@@ sv/datetime_text_parser_top.sv @@
// Result path: an end-of-text item is registered in the input register, and the core then
// registers the result and m_tvalid in the result register.
// Throughput: one character item per cycle; the parse state updates in a single pass
// between the input register and the result register. An end-of-text item waits in the
// input register while the previous result is stalled, which holds off s_tready.
// Reset: synchronous, active-low aresetn clears the parse state and both valid flags;
// the input register is empty after reset, so s_tready is high and the block accepts items.
module datetime_text_parser_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // ch
    input  logic                        s_tlast,   // end_of_text
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [dtp_pkg::TDATA_W-1:0] m_tdata,   // year, month, day, hour, minute, second, pad
    output logic                        m_tuser    // ok
);

    logic              item_valid;
    logic              take;
    dtp_pkg::in_item_t item;
    dtp_pkg::result_t  res;

    dtp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    dtp_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .res_ready  (m_tready),
        .res_valid  (m_tvalid),
        .res        (res)
    );

    assign m_tdata = {2'b00, res.second, res.minute, res.hour, res.day, res.month, res.year};
    assign m_tuser = res.ok;

endmodule

@@ sv/dtp_checker.sv @@
module dtp_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [dtp_pkg::TDATA_W-1:0] m_tdata,
    input logic                        m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("failed result carries nonzero fields");

    a_ok_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            m_tdata[11:0] >= 12'd2000 && m_tdata[11:0] <= 12'd2099
            && m_tdata[15:12] != 4'd0 && m_tdata[15:12] <= 4'd12
            && m_tdata[20:16] != 5'd0 && m_tdata[25:21] <= 5'd23
            && m_tdata[31:26] <= 6'd59 && m_tdata[37:32] <= 6'd59
            && m_tdata[39:38] == 2'b00)
        else $error("ok result out of range");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

endmodule

bind datetime_text_parser_top dtp_checker u_dtp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
